// ===== rtl/wkalm_pkg.sv =====
// Shared types, constants and helper functions of the weekly alarm block.
`timescale 1ns / 1ps

package wkalm_pkg;

  localparam int TIME_W  = 32;
  localparam int ALARM_W = 17;
  localparam int MASK_W  = 7;
  localparam int DAY_W   = 16;
  localparam int WD_W    = 3;
  localparam int REM_W   = 18;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = ALARM_W;

  localparam int DAYS_PER_WEEK  = 7;
  localparam int CAND_DAYS      = 8;
  localparam int EPOCH_WEEKDAY  = 4;

  localparam logic [TIME_W-1:0] SEC_PER_DAY = 32'd86400;

  // now / 86400 = (now >> 7) / 675; the quotient of the 25-bit value comes from
  // a multiply by floor(2^35 / 675), which is exact or one low.
  localparam int DIV_PRE   = 7;
  localparam int DIV_SHIFT = 35;
  localparam int MUL_W     = 26;
  localparam logic [MUL_W-1:0] DIV_MUL = 26'd50903316;
  localparam int PROD_W    = TIME_W - DIV_PRE + MUL_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ALARM_SECOND = 8'd0,
    REG_WEEKDAY_MASK = 8'd1
  } cfg_reg_t;

  // One classified query on its way from the front end to the back end.
  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] base;     // midnight of today plus the alarm second
    logic [WD_W-1:0]   weekday;  // weekday of today, 0 is Sunday
  } job_t;

  // Day count to weekday. Since 8 is 1 modulo 7, the octal digits are summed.
  function automatic logic [WD_W-1:0] day_to_weekday(input logic [DAY_W-1:0] days);
    logic [5:0] s;
    logic [3:0] t;
    logic [3:0] r;
    s = 6'(days[2:0]) + 6'(days[5:3]) + 6'(days[8:6]) + 6'(days[11:9])
      + 6'(days[14:12]) + 6'(days[15]);
    t = 4'(s[2:0]) + 4'(s[5:3]);
    r = (t >= 4'(DAYS_PER_WEEK)) ? t - 4'(DAYS_PER_WEEK) : t;
    r = r + 4'(EPOCH_WEEKDAY);
    r = (r >= 4'(DAYS_PER_WEEK)) ? r - 4'(DAYS_PER_WEEK) : r;
    return r[WD_W-1:0];
  endfunction

  // Weekday that lies a given number of days (0 to 7) after another one.
  function automatic logic [WD_W-1:0] weekday_add(input logic [WD_W-1:0] wd,
                                                  input logic [WD_W:0]   step);
    logic [WD_W:0] t;
    t = {1'b0, wd} + step;
    t = (t >= 4'(DAYS_PER_WEEK)) ? t - 4'(DAYS_PER_WEEK) : t;
    return t[WD_W-1:0];
  endfunction

endpackage

// ===== rtl/wkalm_front.sv =====
// Front end: splits the time into day count and midnight, forms today's candidate.
`timescale 1ns / 1ps

module wkalm_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [wkalm_pkg::TIME_W-1:0]    in_current_time,
  input  logic [wkalm_pkg::ALARM_W-1:0]   alarm_second,
  output logic                            push_valid,
  output wkalm_pkg::job_t                 push_job,
  input  logic                            queue_full
);

  logic                             fe_en;
  logic                             s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [wkalm_pkg::TIME_W-1:0]     s1_now_r, s2_now_r, s3_now_r;
  logic [wkalm_pkg::DAY_W-1:0]      s1_q_r, s2_q_r, s3_days_r;
  logic [wkalm_pkg::TIME_W-1:0]     s2_m_r, s3_mid_r;
  wkalm_pkg::job_t                  s4_job_r;

  logic [wkalm_pkg::PROD_W-1:0]     prod;
  logic [wkalm_pkg::TIME_W:0]       m_full;
  logic [wkalm_pkg::TIME_W-1:0]     rem_full;
  logic [wkalm_pkg::REM_W-1:0]      rem;
  logic                             rem_ge;
  logic [wkalm_pkg::DAY_W-1:0]      s1_q_nxt, s3_days_nxt;
  logic [wkalm_pkg::TIME_W-1:0]     s2_m_nxt, s3_mid_nxt;
  wkalm_pkg::job_t                  s4_job_nxt;

  // The whole front end advances together unless its last stage is blocked.
  assign fe_en      = !s4_v_r || !queue_full;
  assign in_ready   = fe_en;
  assign push_valid = s4_v_r && !queue_full;
  assign push_job   = s4_job_r;

  always_comb begin
    prod     = wkalm_pkg::PROD_W'(in_current_time[wkalm_pkg::TIME_W-1:wkalm_pkg::DIV_PRE])
             * wkalm_pkg::PROD_W'(wkalm_pkg::DIV_MUL);
    s1_q_nxt = prod[wkalm_pkg::DIV_SHIFT +: wkalm_pkg::DAY_W];

    m_full   = (wkalm_pkg::TIME_W+1)'(s1_q_r) * (wkalm_pkg::TIME_W+1)'(wkalm_pkg::SEC_PER_DAY);
    s2_m_nxt = m_full[wkalm_pkg::TIME_W-1:0];

    // The estimate may be one day short; the remainder then reaches a full day.
    rem_full    = s2_now_r - s2_m_r;
    rem         = rem_full[wkalm_pkg::REM_W-1:0];
    rem_ge      = rem >= wkalm_pkg::REM_W'(wkalm_pkg::SEC_PER_DAY);
    s3_mid_nxt  = rem_ge ? s2_m_r + wkalm_pkg::SEC_PER_DAY : s2_m_r;
    s3_days_nxt = s2_q_r + wkalm_pkg::DAY_W'(rem_ge);

    s4_job_nxt.now     = s3_now_r;
    s4_job_nxt.base    = s3_mid_r + wkalm_pkg::TIME_W'(alarm_second);
    s4_job_nxt.weekday = wkalm_pkg::day_to_weekday(s3_days_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (fe_en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe_en) begin
      s1_now_r  <= in_current_time;
      s1_q_r    <= s1_q_nxt;
      s2_now_r  <= s1_now_r;
      s2_q_r    <= s1_q_r;
      s2_m_r    <= s2_m_nxt;
      s3_now_r  <= s2_now_r;
      s3_mid_r  <= s3_mid_nxt;
      s3_days_r <= s3_days_nxt;
      s4_job_r  <= s4_job_nxt;
    end
  end

  a_stall_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && queue_full) |=> s4_v_r && $stable(s4_job_r))
    else $error("front end lost a beat while the queue was full");

  a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> s4_job_r.weekday != 3'(wkalm_pkg::DAYS_PER_WEEK))
    else $error("weekday out of range");

endmodule

// ===== rtl/wkalm_queue.sv =====
// Small FIFO that decouples the front end from the back end.
`timescale 1ns / 1ps

module wkalm_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  wkalm_pkg::job_t  push_job,
  output logic             full,
  output logic             pop_valid,
  input  logic             pop,
  output wkalm_pkg::job_t  pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wkalm_pkg::job_t    mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full      = count_r == CNT_W'(DEPTH);
  assign pop_valid = count_r != '0;
  assign pop_job   = mem_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || full) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

endmodule

// ===== rtl/wkalm_back.sv =====
// Back end: checks eight candidate days against the mask and picks the first hit.
`timescale 1ns / 1ps

module wkalm_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           job_valid,
  output logic                           job_pop,
  input  wkalm_pkg::job_t                job,
  input  logic [wkalm_pkg::MASK_W-1:0]   weekday_mask,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_found,
  output logic [wkalm_pkg::TIME_W-1:0]   out_next_time
);

  localparam int N = wkalm_pkg::CAND_DAYS;

  logic                           be_en, b1_free;
  logic                           b1_v_r, b1_v_nxt;
  logic [wkalm_pkg::TIME_W-1:0]   b1_now_r;
  logic [wkalm_pkg::TIME_W-1:0]   b1_cand_r   [N];
  logic [wkalm_pkg::TIME_W-1:0]   b1_cand_nxt [N];
  logic [N-1:0]                   b1_en_r, b1_en_nxt;
  logic                           out_valid_r, out_found_r, out_found_nxt;
  logic [wkalm_pkg::TIME_W-1:0]   out_next_time_r, out_next_time_nxt;

  assign be_en    = !out_valid_r || out_ready;
  assign b1_free  = !b1_v_r || be_en;
  assign job_pop  = job_valid && b1_free;
  assign b1_v_nxt = b1_free ? job_valid : 1'b1;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      b1_cand_nxt[i] = job.base + wkalm_pkg::TIME_W'(i) * wkalm_pkg::SEC_PER_DAY;
      b1_en_nxt[i]   = weekday_mask[wkalm_pkg::weekday_add(job.weekday,
                                                           (wkalm_pkg::WD_W+1)'(i))];
    end
  end

  // The latest day is checked first so that the earliest hit wins.
  always_comb begin
    out_found_nxt     = 1'b0;
    out_next_time_nxt = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (b1_en_r[i] && (b1_now_r < b1_cand_r[i])) begin
        out_found_nxt     = 1'b1;
        out_next_time_nxt = b1_cand_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b1_v_r <= b1_v_nxt;
      if (be_en) begin
        out_valid_r <= b1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      b1_now_r  <= job.now;
      b1_cand_r <= b1_cand_nxt;
      b1_en_r   <= b1_en_nxt;
    end
    if (be_en) begin
      out_found_r     <= out_found_nxt;
      out_next_time_r <= out_next_time_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_next_time = out_next_time_r;

  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> out_next_time_r == '0)
    else $error("result without a hit carries a nonzero time");

  a_b1_held: assert property (@(posedge clk) disable iff (!rst_n)
    (b1_v_r && !be_en) |=> b1_v_r && $stable(b1_now_r))
    else $error("candidate stage overwritten while the output stalled");

endmodule

// ===== rtl/weekly_alarm_next_time.sv =====
// Top level of the weekly alarm next-trigger-time block with its configuration registers.
// Throughput: one beat per cycle unless output stalls have filled the queue; beats pass
// the four-stage divide-by-day front end, the queue and the two-stage candidate back end.
// The queue (QUEUE_DEPTH entries) absorbs output stalls, so beats are taken until it fills.
// Synchronous active-low reset empties every stage and the queue and clears both registers.
`timescale 1ns / 1ps

module weekly_alarm_next_time #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [wkalm_pkg::TIME_W-1:0]        in_current_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic [wkalm_pkg::TIME_W-1:0]        out_next_time,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wkalm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [wkalm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [wkalm_pkg::ALARM_W-1:0]  alarm_second_r, alarm_second_nxt;
  logic [wkalm_pkg::MASK_W-1:0]   weekday_mask_r, weekday_mask_nxt;
  logic                           push_valid, queue_full, pop_valid, pop;
  wkalm_pkg::job_t                push_job, pop_job;

  assign cfg_ready = 1'b1;

  always_comb begin
    alarm_second_nxt = alarm_second_r;
    weekday_mask_nxt = weekday_mask_r;
    if (cfg_valid) begin
      case (cfg_index)
        wkalm_pkg::REG_ALARM_SECOND: alarm_second_nxt = cfg_data[wkalm_pkg::ALARM_W-1:0];
        wkalm_pkg::REG_WEEKDAY_MASK: weekday_mask_nxt = cfg_data[wkalm_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_second_r <= '0;
      weekday_mask_r <= '0;
    end else begin
      alarm_second_r <= alarm_second_nxt;
      weekday_mask_r <= weekday_mask_nxt;
    end
  end

  wkalm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_current_time (in_current_time),
    .alarm_second    (alarm_second_r),
    .push_valid      (push_valid),
    .push_job        (push_job),
    .queue_full      (queue_full)
  );

  wkalm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .full       (queue_full),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_job    (pop_job)
  );

  wkalm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (pop_valid),
    .job_pop       (pop),
    .job           (pop_job),
    .weekday_mask  (weekday_mask_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_found     (out_found),
    .out_next_time (out_next_time)
  );

  a_empty_mask_misses: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && weekday_mask_r == '0 && $stable(weekday_mask_r)
     && $past(weekday_mask_r, 6) == '0) |-> !out_found)
    else $error("hit reported with an empty weekday mask");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the weekly alarm next-trigger-time block.
`timescale 1ns / 1ps

module testbench;

  localparam logic [wkalm_pkg::TIME_W-1:0]      SEC_PER_WEEK       = 32'd604800;
  localparam logic [wkalm_pkg::CFG_INDEX_W-1:0] FIRST_UNMAPPED_REG = 8'd2;
  localparam logic [wkalm_pkg::CFG_INDEX_W-1:0] LAST_UNMAPPED_REG  = 8'hFF;
  localparam int                                MAX_DAY_INDEX      = 49710;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASE_QUERIES   = 125;
  localparam int RANDOM_PHASES   = 8;
  localparam int SETTLE_CYCLES   = 10;

  typedef struct packed {
    logic                         found;
    logic [wkalm_pkg::TIME_W-1:0] next_time;
  } alarm_hit_t;

  // Keeps a copy of both registers and the alarm times still owed by the block.
  class alarm_scoreboard;
    logic [wkalm_pkg::ALARM_W-1:0] alarm_sec;
    logic [wkalm_pkg::MASK_W-1:0]  day_mask;
    alarm_hit_t                    expected_hits[$];
    int                            errors;

    function new();
      alarm_sec = '0;
      day_mask  = '0;
      errors    = 0;
    endfunction

    function void write_register(logic [wkalm_pkg::CFG_INDEX_W-1:0] idx,
                                 logic [wkalm_pkg::CFG_DATA_W-1:0] data);
      if (idx == wkalm_pkg::REG_ALARM_SECOND) begin
        alarm_sec = data[wkalm_pkg::ALARM_W-1:0];
      end else if (idx == wkalm_pkg::REG_WEEKDAY_MASK) begin
        day_mask = data[wkalm_pkg::MASK_W-1:0];
      end
    endfunction

    // Walks up to eight candidate days from today's midnight plus the alarm second.
    // The weekday of each candidate follows the midnight it was added to.
    function void note_query(logic [wkalm_pkg::TIME_W-1:0] now);
      logic [wkalm_pkg::TIME_W-1:0] cand;
      int unsigned                  today;
      alarm_hit_t                   hit;
      hit   = '0;
      today = ((now % SEC_PER_WEEK) / wkalm_pkg::SEC_PER_DAY + wkalm_pkg::EPOCH_WEEKDAY)
            % wkalm_pkg::DAYS_PER_WEEK;
      cand  = now - (now % wkalm_pkg::SEC_PER_DAY);
      cand  = cand + alarm_sec;
      for (int i = 0; i < wkalm_pkg::CAND_DAYS; i++) begin
        if (!hit.found && now < cand
            && day_mask[(today + i) % wkalm_pkg::DAYS_PER_WEEK]) begin
          hit.found     = 1'b1;
          hit.next_time = cand;
        end
        cand = cand + wkalm_pkg::SEC_PER_DAY;
      end
      expected_hits.push_back(hit);
    endfunction

    function void check_alarm(logic found, logic [wkalm_pkg::TIME_W-1:0] next_time);
      alarm_hit_t exp_hit;
      if (expected_hits.size() == 0) begin
        $error("unexpected result beat: found %0d, next_time %0d", found, next_time);
        errors++;
      end else begin
        exp_hit = expected_hits.pop_front();
        if (found !== exp_hit.found) begin
          $error("found: expected %0d, got %0d", exp_hit.found, found);
          errors++;
        end
        if (next_time !== exp_hit.next_time) begin
          $error("next_time: expected %0d, got %0d", exp_hit.next_time, next_time);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction
  endclass

  logic                              clk             = 1'b0;
  logic                              rst_n           = 1'b0;
  logic                              in_valid        = 1'b0;
  logic                              in_ready;
  logic [wkalm_pkg::TIME_W-1:0]      in_current_time = '0;
  logic                              out_valid;
  logic                              out_ready       = 1'b0;
  logic                              out_found;
  logic [wkalm_pkg::TIME_W-1:0]      out_next_time;
  logic                              cfg_valid       = 1'b0;
  logic                              cfg_ready;
  logic [wkalm_pkg::CFG_INDEX_W-1:0] cfg_index       = '0;
  logic [wkalm_pkg::CFG_DATA_W-1:0]  cfg_data        = '0;

  alarm_scoreboard sb = new();
  bit              quiet_run = 1'b0;
  bit              hold_req  = 1'b0;
  int              idle_cycles = 0;

  weekly_alarm_next_time u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_current_time (in_current_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_next_time   (out_next_time),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Mostly back to back, often short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_run || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Beats are noted and checked here; the watchdog counts cycles without any beat.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      sb.write_register(cfg_index, cfg_data);
    end
    if (rst_n && in_valid && in_ready) begin
      sb.note_query(in_current_time);
    end
    if (rst_n && out_valid && out_ready) begin
      sb.check_alarm(out_found, out_next_time);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin
    int stall;
    forever begin
      if (hold_req) begin
        stall    = HOLD_OFF_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic send_query(input logic [wkalm_pkg::TIME_W-1:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_current_time <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits until the last input beat is noted, then until every result is back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic cfg_beat(input logic [wkalm_pkg::CFG_INDEX_W-1:0] idx,
                          input logic [wkalm_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [wkalm_pkg::CFG_DATA_W-1:0] alarm,
                           input logic [wkalm_pkg::CFG_DATA_W-1:0] mask_data);
    drain();
    cfg_beat(wkalm_pkg::REG_ALARM_SECOND, alarm);
    cfg_beat(wkalm_pkg::REG_WEEKDAY_MASK, mask_data);
    // Writes to indexes past the register list must leave both registers alone.
    if ($urandom_range(0, 1)) begin
      cfg_beat(wkalm_pkg::CFG_INDEX_W'($urandom_range(FIRST_UNMAPPED_REG, LAST_UNMAPPED_REG)),
               wkalm_pkg::CFG_DATA_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [wkalm_pkg::TIME_W-1:0] pick_time();
    logic [wkalm_pkg::TIME_W-1:0] t;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: t = $urandom;
      4, 5, 6: begin
        // Right around an alarm moment, to hit the strictly-later test.
        t = wkalm_pkg::TIME_W'($urandom_range(0, MAX_DAY_INDEX)) * wkalm_pkg::SEC_PER_DAY;
        t = t + sb.alarm_sec + wkalm_pkg::TIME_W'($urandom_range(0, 4)) - 32'd2;
      end
      7: t = 32'hFFFF_FFFF - wkalm_pkg::TIME_W'($urandom_range(0, 700000));
      8: begin
        t = wkalm_pkg::TIME_W'($urandom_range(0, MAX_DAY_INDEX)) * wkalm_pkg::SEC_PER_DAY;
        t = t + wkalm_pkg::TIME_W'($urandom_range(0, 3)) - 32'd2;
      end
      default: t = wkalm_pkg::TIME_W'($urandom_range(0, 700000));
    endcase
    return t;
  endfunction

  task automatic run_phase(input int p);
    logic [wkalm_pkg::CFG_DATA_W-1:0] alarm;
    logic [wkalm_pkg::CFG_DATA_W-1:0] mask_data;
    case ($urandom_range(0, 5))
      0: alarm = '0;
      1: alarm = wkalm_pkg::CFG_DATA_W'(wkalm_pkg::SEC_PER_DAY - 1);
      2: alarm = '1;
      3: alarm = wkalm_pkg::CFG_DATA_W'($urandom_range(wkalm_pkg::SEC_PER_DAY, 131071));
      default: alarm = wkalm_pkg::CFG_DATA_W'($urandom_range(0, wkalm_pkg::SEC_PER_DAY - 1));
    endcase
    case ($urandom_range(0, 7))
      0: mask_data = '0;
      1: mask_data = wkalm_pkg::CFG_DATA_W'(7'h7F);
      2: mask_data = wkalm_pkg::CFG_DATA_W'($urandom);
      default: mask_data = wkalm_pkg::CFG_DATA_W'($urandom_range(1, 127));
    endcase
    if (p == 0) begin
      alarm     = '1;
      mask_data = wkalm_pkg::CFG_DATA_W'(7'h7F);
    end else if (p == 1) begin
      alarm = '0;
    end
    configure(alarm, mask_data);
    quiet_run = (p == 2 || p == 4);
    // With the sender at full rate, this hold-off fills the block and stalls its input.
    if (p == 4) begin
      hold_req = 1'b1;
    end
    repeat (PHASE_QUERIES) send_query(pick_time());
    quiet_run = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Registers still at reset: the mask is empty.
    send_query(32'd0);
    send_query(32'hFFFF_FFFF);

    // Every day enabled, alarm at midnight.
    configure(17'd0, wkalm_pkg::CFG_DATA_W'(7'h7F));
    send_query(32'd0);
    send_query(32'd1);
    send_query(32'd86399);
    send_query(32'd86400);

    // Sundays only, last second of the day; an unmapped write follows.
    configure(17'd86399, wkalm_pkg::CFG_DATA_W'(7'h01));
    cfg_beat(LAST_UNMAPPED_REG, '1);
    cfg_valid <= 1'b0;
    send_query(32'd0);
    send_query(32'd86399);
    send_query(32'd86398);
    send_query(32'd345599);

    // Alarm second past one day; upper mask data bits must be dropped.
    configure('1, 17'h1FFC0);
    send_query(32'd100000);
    send_query(32'd0);
    send_query(32'd604799);
    send_query(32'hFFFF_FFFF);

    // Candidates near the top of the count wrap below the current time.
    configure(17'd50000, wkalm_pkg::CFG_DATA_W'(7'h7F));
    send_query(32'hFFFF_FFFF);
    send_query(32'hFFFF_FFFF - 32'd30000);
    send_query(32'd4294950000);
    send_query(32'd4294944000 - 32'd1);

    // Empty mask written explicitly.
    configure(17'd12345, '0);
    send_query(32'hFFFF_FFFF);
    send_query(32'd12344);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      run_phase(p);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
